// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the keystream cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge except while reset is high.
`define JKKC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define JKKC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JKKC_ASSERT(label, clk, rst, prop, msg)
`define JKKC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hdl/jkkc_pkg.sv -----
// Package with widths, seeds and the keystream byte function of the JK keystream cipher.
package jkkc_pkg;

  localparam int unsigned TAP_W  = 4;
  localparam int unsigned BYTE_W = 8;

  localparam logic [TAP_W-1:0] SEED_FIRST  = 4'hC;
  localparam logic [TAP_W-1:0] SEED_SECOND = 4'h9;

  // Generator state carried from byte to byte.
  typedef struct packed {
    logic [TAP_W-1:0] first;
    logic [TAP_W-1:0] second;
    logic             flop;
  } gen_state_t;

  // Keystream byte together with the state it leaves behind.
  typedef struct packed {
    logic [BYTE_W-1:0] ks;
    gen_state_t        state;
  } ks_result_t;

  // Run eight bit steps of both LFSRs and the JK flop, first bit on the MSB.
  function automatic ks_result_t ks_byte(gen_state_t st, logic [TAP_W-1:0] taps);
    ks_result_t       res;
    logic [TAP_W-1:0] f;
    logic [TAP_W-1:0] s;
    logic             q;
    logic             j;
    logic             k;
    f = st.first;
    s = st.second;
    q = st.flop;
    res.ks = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      j = f[0];
      k = s[0];
      f = {^(f & taps), f[TAP_W-1:1]};
      s = {^(s & taps), s[TAP_W-1:1]};
      case ({j, k})
        2'b11:   q = ~q;
        2'b10:   q = 1'b1;
        2'b01:   q = 1'b0;
        default: q = q;
      endcase
      res.ks[BYTE_W-1-b] = q;
    end
    res.state.first  = f;
    res.state.second = s;
    res.state.flop   = q;
    return res;
  endfunction

endpackage

// ----- hdl/jk_flipflop_keystream_cipher.sv -----
// JK flip-flop keystream cipher: input register, keystream byte logic and result register.
// The block takes one data byte per clock while data_stall is low and returns it XORed
// with eight keystream bits from two 4-bit LFSRs driving a JK flop, first bit on the MSB.
// An accepted transaction waits in the input register and moves into the result register
// once that is free; the sustained rate is one byte per cycle while the result channel
// does not stall, set by the single register stage that runs all eight bit steps of the
// LFSRs and the flop at once and updates the generator state in the same cycle. A set
// message_start bit reloads the seeds and clears the flop before its byte. The feedback
// taps are written through the configuration channel, which is always ready.
`include "assert_macros.svh"

module jk_flipflop_keystream_cipher (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [jkkc_pkg::TAP_W-1:0]  cfg_data,
  // Input channel
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [jkkc_pkg::BYTE_W-1:0] data_byte,
  input  logic                        message_start,
  // Result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [jkkc_pkg::BYTE_W-1:0] result_byte
);

  logic [jkkc_pkg::TAP_W-1:0]  feedback_taps;
  logic                        in_valid;
  logic [jkkc_pkg::BYTE_W-1:0] in_byte;
  logic                        in_start;
  jkkc_pkg::gen_state_t        gen_state;
  jkkc_pkg::gen_state_t        gen_base;
  jkkc_pkg::ks_result_t        ks_res;
  logic                        out_free;
  logic                        advance;
  logic                        accept;

  // Flow control: the input register moves on when the result register is free.
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_valid && out_free;
  assign data_stall = in_valid && !out_free;
  assign accept     = data_valid && !data_stall;

  // Tap register, written by a configuration transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_taps <= '0;
    end else if (cfg_valid && cfg_ready) begin
      feedback_taps <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte  <= data_byte;
      in_start <= message_start;
    end
  end

  // Keystream logic, starting from the seeds when a message begins.
  always_comb begin
    if (in_start) begin
      gen_base.first  = jkkc_pkg::SEED_FIRST;
      gen_base.second = jkkc_pkg::SEED_SECOND;
      gen_base.flop   = 1'b0;
    end else begin
      gen_base = gen_state;
    end
    ks_res = jkkc_pkg::ks_byte(gen_base, feedback_taps);
  end

  // Generator state, updated once per byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state.first  <= jkkc_pkg::SEED_FIRST;
      gen_state.second <= jkkc_pkg::SEED_SECOND;
      gen_state.flop   <= 1'b0;
    end else if (advance) begin
      gen_state <= ks_res.state;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_byte <= in_byte ^ ks_res.ks;
    end
  end

  // Checks on the internal pipeline and state.
  `JKKC_ASSERT_ALWAYS(a_reset_seeds, clk, rst |=> (gen_state.first == jkkc_pkg::SEED_FIRST && gen_state.second == jkkc_pkg::SEED_SECOND && !gen_state.flop), "generator state not at seeds after reset")
  `JKKC_ASSERT(a_advance_result, clk, rst, advance |=> result_valid, "advanced transaction did not reach the result register")
  `JKKC_ASSERT(a_stall_full, clk, rst, data_stall |-> (in_valid && result_valid), "input stalled without a full pipeline")
  `JKKC_ASSERT(a_taps_hold, clk, rst, !cfg_valid |=> $stable(feedback_taps), "feedback taps changed without a write")
  `JKKC_ASSERT(a_state_hold, clk, rst, !advance |=> $stable(gen_state), "generator state changed without a byte")

endmodule
